// ----- rtl/core/rts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_pkg
// shared types, constants and sequencing helpers for the regeneration
// time statistics block
// ----------------------------------------------------------------------------
package rts_pkg;

  localparam int ITER_BITS  = 24;
  localparam int FRAC_BITS  = 16;
  localparam int SUM_W      = 64;
  localparam int HALF_W     = SUM_W / 2;
  localparam int WIDE_W     = 2 * SUM_W;
  localparam int MEAN_W     = ITER_BITS + FRAC_BITS;
  localparam int FRACQ_W    = FRAC_BITS + 1;
  localparam int OUT_W      = 32;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  localparam logic [ITER_BITS-1:0] MIN_VISITS = ITER_BITS'(5);
  localparam logic [ITER_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [SUM_W-1:0]     ONE_Q      = SUM_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0]     LOW32      = SUM_W'(32'hFFFF_FFFF);
  localparam logic [SUM_W-1:0]     SLOPE_NEG  = SUM_W'(32'h8000_0000);
  localparam logic [SUM_W-1:0]     SLOPE_POS  = SUM_W'(32'h7FFF_FFFF);
  localparam logic [SUM_W-1:0]     SIGN64     = SUM_W'(1) << (SUM_W - 1);

  localparam logic OP_VISIT  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [ITER_BITS-1:0] iteration;
  } rts_in_t;

  typedef struct packed {
    logic                     enough_visits;
    logic [FRACQ_W-1:0]       frequency;
    logic [OUT_W-1:0]         gap_variation;
    logic signed [OUT_W-1:0]  plot_slope;
    logic [FRACQ_W-1:0]       correlation;
  } rts_out_t;

  // micro-operations, listed in issue order for each sequence
  typedef enum logic [4:0] {
    U_PREP, U_XDIV, U_XUPD, U_XAFT, U_YDIV, U_YUPD, U_YAFT,
    U_GDIV, U_GUPD, U_GAFT, U_MIX, U_SIX, U_MIT, U_SIT,
    U_MGP, U_SGP, U_MCR, U_SCR,
    U_RFQ, U_RG1, U_RG2, U_RG3, U_RG4, U_RA, U_RS1, U_RS2,
    U_RB, U_RC, U_RSQ, U_RFIN
  } rts_uop_t;

  typedef struct packed {
    logic     go;
    rts_uop_t uop;
  } rts_cmd_t;

  typedef struct packed {
    logic done;
  } rts_sta_t;

  function automatic logic rts_uses_unit(rts_uop_t uop);
    logic r;
    case (uop)
      U_XDIV, U_YDIV, U_GDIV, U_MIX, U_MIT, U_MGP, U_MCR,
      U_RFQ, U_RG1, U_RG2, U_RG3, U_RG4, U_RA, U_RS1, U_RS2,
      U_RB, U_RC, U_RSQ: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic rts_is_last(rts_uop_t uop);
    return (uop == U_SCR) || (uop == U_RFIN);
  endfunction

  function automatic rts_uop_t rts_next_uop(rts_uop_t uop);
    return rts_uop_t'(uop + 5'd1);
  endfunction

  function automatic logic [WIDE_W-1:0] rts_shl_frac(logic [SUM_W-1:0] x);
    return WIDE_W'(x) << FRAC_BITS;
  endfunction

  function automatic logic [SUM_W-1:0] rts_shr_frac_sat(logic [WIDE_W-1:0] p);
    logic [SUM_W-1:0] r;
    if (p[WIDE_W-1:SUM_W+FRAC_BITS] != '0) r = '1;
    else r = p[SUM_W+FRAC_BITS-1:FRAC_BITS];
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] rts_add_sat(logic [SUM_W-1:0] s,
                                                  logic [SUM_W-1:0] t);
    logic [SUM_W:0] w;
    w = {1'b0, s} + {1'b0, t};
    return w[SUM_W] ? '1 : w[SUM_W-1:0];
  endfunction

endpackage

// ----- rtl/core/rts_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_div
// restoring divider, wide dividend by 64-bit divisor, one bit per cycle,
// quotient saturates when it would not fit
// ----------------------------------------------------------------------------
module rts_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rts_pkg::WIDE_W-1:0]    num,
  input  logic [rts_pkg::SUM_W-1:0]     den,
  output logic                          done,
  output logic [rts_pkg::SUM_W-1:0]     quo
);

  logic                            busy;
  logic [rts_pkg::DIV_CNT_W-1:0]   left;
  logic [rts_pkg::SUM_W-1:0]       rem;
  logic [rts_pkg::SUM_W-1:0]       lo;
  logic [rts_pkg::SUM_W-1:0]       den_q;
  logic [rts_pkg::SUM_W-1:0]       shifted;
  logic                            take;

  assign shifted = {rem[rts_pkg::SUM_W-2:0], lo[rts_pkg::SUM_W-1]};
  assign take    = rem[rts_pkg::SUM_W-1] || (shifted >= den_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_q <= den;
        if (num[rts_pkg::WIDE_W-1:rts_pkg::SUM_W] >= den) begin
          // quotient overflow
          quo  <= '1;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem  <= num[rts_pkg::WIDE_W-1:rts_pkg::SUM_W];
          lo   <= num[rts_pkg::SUM_W-1:0];
          quo  <= '0;
          left <= rts_pkg::DIV_CNT_W'(rts_pkg::SUM_W);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= take ? shifted - den_q : shifted;
        lo   <= lo << 1;
        quo  <= {quo[rts_pkg::SUM_W-2:0], take};
        left <= left - rts_pkg::DIV_CNT_W'(1);
        if (left == rts_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/rts_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_mul
// 64 x 64 multiplier from four 32 x 32 partial products, one per cycle,
// each registered before it is accumulated
// ----------------------------------------------------------------------------
module rts_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rts_pkg::SUM_W-1:0]   a,
  input  logic [rts_pkg::SUM_W-1:0]   b,
  output logic                        done,
  output logic [rts_pkg::WIDE_W-1:0]  prod
);

  logic                          busy;
  logic [2:0]                    ph;
  logic [1:0]                    pph;
  logic [rts_pkg::SUM_W-1:0]     a_q;
  logic [rts_pkg::SUM_W-1:0]     b_q;
  logic [rts_pkg::SUM_W-1:0]     part;
  logic [rts_pkg::HALF_W-1:0]    ah;
  logic [rts_pkg::HALF_W-1:0]    bh;
  logic [rts_pkg::WIDE_W-1:0]    part_sh;

  assign ah = ph[1] ? a_q[rts_pkg::SUM_W-1:rts_pkg::HALF_W] : a_q[rts_pkg::HALF_W-1:0];
  assign bh = ph[0] ? b_q[rts_pkg::SUM_W-1:rts_pkg::HALF_W] : b_q[rts_pkg::HALF_W-1:0];

  always_comb begin
    case (pph)
      2'd0:       part_sh = rts_pkg::WIDE_W'(part);
      2'd1, 2'd2: part_sh = rts_pkg::WIDE_W'(part) << rts_pkg::HALF_W;
      default:    part_sh = rts_pkg::WIDE_W'(part) << rts_pkg::SUM_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q  <= a;
        b_q  <= b;
        prod <= '0;
        ph   <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (ph != 3'd4) begin
          part <= rts_pkg::SUM_W'(ah) * rts_pkg::SUM_W'(bh);
          pph  <= ph[1:0];
        end
        if (ph != 3'd0) prod <= prod + part_sh;
        if (ph == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        ph <= ph + 3'd1;
      end
    end
  end

endmodule

// ----- rtl/core/rts_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_dp
// statistics datapath: running means and centred sums, shared divider,
// multiplier and square root, result register
// ----------------------------------------------------------------------------
module rts_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_take,
  input  rts_pkg::rts_in_t  in_item,
  input  rts_pkg::rts_cmd_t cmd,
  output rts_pkg::rts_sta_t sta,
  output rts_pkg::rts_out_t out_item
);

  localparam int IB = rts_pkg::ITER_BITS;
  localparam int FB = rts_pkg::FRAC_BITS;
  localparam int MW = rts_pkg::MEAN_W;
  localparam int SW = rts_pkg::SUM_W;
  localparam int WW = rts_pkg::WIDE_W;
  localparam int QW = rts_pkg::FRACQ_W;
  localparam int OW = rts_pkg::OUT_W;

  // running state
  logic [IB-1:0] cnt, last, gap, it_q;
  logic [MW-1:0] m_idx, m_it, m_gap;
  logic [SW-1:0] s_ix, s_it, s_gap, s_cr;

  // working values
  logic [MW-1:0] bx, ax, by, ay, bg, ag, stepq;
  logic          nx, ny, ng;
  logic [WW-1:0] prod;
  logic [SW-1:0] v_q, a_q, b_q;
  logic [QW-1:0] c_q, freq, corr;
  logic [OW-1:0] gv, slope;

  // shared units
  logic          div_start, div_done, mul_start, mul_done;
  logic [WW-1:0] div_num, mul_p;
  logic [SW-1:0] div_den, div_q, mul_a, mul_b;
  logic          sq_busy, sq_done;
  logic [SW-1:0] sq_v, sq_res, sq_bit, sq_sum;

  // mean step selection
  logic [MW-1:0] sel_m, sel_xf, dif, m_new;
  logic          sel_neg, neg_c;

  // report helpers
  logic          neg_r;
  logic [SW-1:0] mxy, mag, off, slope_v;
  logic [SW:0]   off_sub;

  always_comb begin
    case (cmd.uop)
      rts_pkg::U_XDIV, rts_pkg::U_XUPD, rts_pkg::U_XAFT: begin
        sel_m = m_idx; sel_xf = {cnt, {FB{1'b0}}}; sel_neg = nx;
      end
      rts_pkg::U_YDIV, rts_pkg::U_YUPD, rts_pkg::U_YAFT: begin
        sel_m = m_it; sel_xf = {it_q, {FB{1'b0}}}; sel_neg = ny;
      end
      default: begin
        sel_m = m_gap; sel_xf = {gap, {FB{1'b0}}}; sel_neg = ng;
      end
    endcase
  end

  assign neg_c = sel_xf < sel_m;
  assign dif   = neg_c ? sel_m - sel_xf : sel_xf - sel_m;
  assign m_new = sel_neg ? sel_m - stepq : sel_m + stepq;

  assign neg_r   = s_cr[SW-1];
  assign mxy     = neg_r ? (~s_cr + SW'(1)) : s_cr;
  assign mag     = rts_pkg::rts_shr_frac_sat(prod);
  assign off     = s_cr ^ rts_pkg::SIGN64;
  assign off_sub = {1'b0, off} - {1'b0, mag};

  always_comb begin
    if (neg_r) slope_v = (div_q > rts_pkg::SLOPE_NEG) ? rts_pkg::SLOPE_NEG : div_q;
    else       slope_v = (div_q > rts_pkg::SLOPE_POS) ? rts_pkg::SLOPE_POS : div_q;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.uop)
      rts_pkg::U_XDIV, rts_pkg::U_YDIV, rts_pkg::U_GDIV: begin
        div_start = cmd.go; div_num = WW'(dif); div_den = SW'(cnt);
      end
      rts_pkg::U_RFQ: begin
        div_start = cmd.go; div_num = WW'({cnt, {FB{1'b0}}}); div_den = SW'(it_q);
      end
      rts_pkg::U_RG1: begin
        div_start = cmd.go; div_num = rts_pkg::rts_shl_frac(s_gap); div_den = SW'(m_gap);
      end
      rts_pkg::U_RG2: begin
        div_start = cmd.go; div_num = rts_pkg::rts_shl_frac(v_q); div_den = SW'(m_gap);
      end
      rts_pkg::U_RG3, rts_pkg::U_RG4: begin
        div_start = cmd.go; div_num = WW'(v_q); div_den = SW'(cnt);
      end
      rts_pkg::U_RA: begin
        div_start = cmd.go; div_num = rts_pkg::rts_shl_frac(mxy); div_den = s_ix;
      end
      rts_pkg::U_RS2: begin
        div_start = cmd.go; div_num = prod; div_den = SW'(last);
      end
      rts_pkg::U_RB: begin
        div_start = cmd.go; div_num = rts_pkg::rts_shl_frac(mxy); div_den = s_it;
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (cmd.uop)
      rts_pkg::U_MIX: begin mul_start = cmd.go; mul_a = SW'(bx); mul_b = SW'(ax); end
      rts_pkg::U_MIT: begin mul_start = cmd.go; mul_a = SW'(by); mul_b = SW'(ay); end
      rts_pkg::U_MGP: begin mul_start = cmd.go; mul_a = SW'(bg); mul_b = SW'(ag); end
      rts_pkg::U_MCR: begin mul_start = cmd.go; mul_a = SW'(bx); mul_b = SW'(ay); end
      rts_pkg::U_RS1: begin mul_start = cmd.go; mul_a = a_q; mul_b = SW'(cnt); end
      rts_pkg::U_RC:  begin mul_start = cmd.go; mul_a = a_q; mul_b = b_q; end
      default: ;
    endcase
  end

  rts_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  rts_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // integer square root, one result bit per step, probe bit moving down two places
  assign sq_sum = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else begin
      sq_done <= 1'b0;
      if (cmd.go && cmd.uop == rts_pkg::U_RSQ) begin
        sq_v    <= SW'(c_q) << FB;
        sq_res  <= '0;
        sq_bit  <= SW'(1) << (SW - 2);
        sq_busy <= 1'b1;
      end else if (sq_busy) begin
        if (sq_v >= sq_sum) begin
          sq_v   <= sq_v - sq_sum;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit == SW'(1)) begin
          sq_busy <= 1'b0;
          sq_done <= 1'b1;
        end
      end
    end
  end

  assign sta.done = div_done | mul_done | sq_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      last  <= '0;
      m_idx <= '0;
      m_it  <= '0;
      m_gap <= '0;
      s_ix  <= '0;
      s_it  <= '0;
      s_gap <= '0;
      s_cr  <= '0;
    end else begin
      if (in_take) it_q <= in_item.iteration;

      // actions taken when a step is issued
      if (cmd.go) begin
        case (cmd.uop)
          rts_pkg::U_PREP: begin
            gap  <= it_q - last;
            last <= it_q;
            if (cnt != rts_pkg::COUNT_MAX) cnt <= cnt + IB'(1);
          end
          rts_pkg::U_XDIV: begin bx <= dif; nx <= neg_c; end
          rts_pkg::U_YDIV: begin by <= dif; ny <= neg_c; end
          rts_pkg::U_GDIV: begin bg <= dif; ng <= neg_c; end
          rts_pkg::U_XUPD: m_idx <= m_new;
          rts_pkg::U_YUPD: m_it  <= m_new;
          rts_pkg::U_GUPD: m_gap <= m_new;
          rts_pkg::U_XAFT: ax <= dif;
          rts_pkg::U_YAFT: ay <= dif;
          rts_pkg::U_GAFT: ag <= dif;
          rts_pkg::U_SIX:  s_ix  <= rts_pkg::rts_add_sat(s_ix, mag);
          rts_pkg::U_SIT:  s_it  <= rts_pkg::rts_add_sat(s_it, mag);
          rts_pkg::U_SGP:  s_gap <= rts_pkg::rts_add_sat(s_gap, mag);
          rts_pkg::U_SCR: begin
            // offset-binary add or subtract, clipped at both ends
            if (nx != ny) s_cr <= (off_sub[SW] ? '0 : off_sub[SW-1:0]) ^ rts_pkg::SIGN64;
            else          s_cr <= rts_pkg::rts_add_sat(off, mag) ^ rts_pkg::SIGN64;
          end
          rts_pkg::U_RFIN: begin
            if (cnt > rts_pkg::MIN_VISITS) begin
              out_item.enough_visits <= 1'b1;
              out_item.frequency     <= freq;
              out_item.gap_variation <= gv;
              out_item.plot_slope    <= slope;
              out_item.correlation   <= corr;
            end else begin
              out_item <= '0;
            end
          end
          default: ;
        endcase
      end

      // unit results
      if (sta.done) begin
        case (cmd.uop)
          rts_pkg::U_XDIV, rts_pkg::U_YDIV, rts_pkg::U_GDIV: stepq <= div_q[MW-1:0];
          rts_pkg::U_MIX, rts_pkg::U_MIT, rts_pkg::U_MGP, rts_pkg::U_MCR,
          rts_pkg::U_RS1: prod <= mul_p;
          rts_pkg::U_RFQ: begin
            if (it_q == '0) freq <= '0;
            else freq <= (div_q > rts_pkg::ONE_Q) ? rts_pkg::ONE_Q[QW-1:0] : div_q[QW-1:0];
          end
          rts_pkg::U_RG1, rts_pkg::U_RG2, rts_pkg::U_RG3: v_q <= div_q;
          rts_pkg::U_RG4: begin
            if (m_gap == '0) gv <= '0;
            else gv <= (div_q > rts_pkg::LOW32) ? '1 : div_q[OW-1:0];
          end
          rts_pkg::U_RA: a_q <= div_q;
          rts_pkg::U_RS2: begin
            if (s_ix == '0 || last == '0) slope <= '0;
            else if (neg_r) slope <= OW'(~slope_v + SW'(1));
            else slope <= slope_v[OW-1:0];
          end
          rts_pkg::U_RB: b_q <= div_q;
          rts_pkg::U_RC: begin
            c_q <= (rts_pkg::rts_shr_frac_sat(mul_p) > rts_pkg::ONE_Q)
                   ? rts_pkg::ONE_Q[QW-1:0] : mul_p[QW+FB-1:FB];
          end
          rts_pkg::U_RSQ: begin
            if (s_ix == '0 || s_it == '0) corr <= '0;
            else corr <= (sq_res > rts_pkg::ONE_Q) ? rts_pkg::ONE_Q[QW-1:0]
                                                   : sq_res[QW-1:0];
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/rts_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rts_ctrl
// sequencer: steps the datapath through the visit or report sequence
// and owns the result valid flag
// ----------------------------------------------------------------------------
module rts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_take,
  input  logic              in_op,
  input  logic              out_take,
  input  rts_pkg::rts_sta_t sta,
  output rts_pkg::rts_cmd_t cmd,
  output logic              in_stall,
  output logic              out_valid
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  state_t            state;
  rts_pkg::rts_uop_t uop;
  logic              out_free;
  logic              go;
  logic              out_valid_next;

  assign out_free = !out_valid || out_take;
  assign go       = (state == ST_RUN) && (uop != rts_pkg::U_RFIN || out_free);
  assign cmd.go   = go;
  assign cmd.uop  = uop;
  assign in_stall = (state != ST_IDLE);

  // result held until taken, raised by the final report step
  assign out_valid_next = (out_valid && !out_take) || (go && uop == rts_pkg::U_RFIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      uop       <= rts_pkg::U_PREP;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            uop   <= (in_op == rts_pkg::OP_REPORT) ? rts_pkg::U_RFQ : rts_pkg::U_PREP;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (go) begin
            if (rts_pkg::rts_uses_unit(uop)) begin
              state <= ST_WAIT;
            end else if (rts_pkg::rts_is_last(uop)) begin
              state <= ST_IDLE;
            end else begin
              uop <= rts_pkg::rts_next_uop(uop);
            end
          end
        end
        ST_WAIT: begin
          if (sta.done) begin
            uop   <= rts_pkg::rts_next_uop(uop);
            state <= ST_RUN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_valid_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(uop == rts_pkg::U_RFIN))
    else $error("result raised outside the final step");

  a_wait_on_unit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT) |-> rts_pkg::rts_uses_unit(uop))
    else $error("waiting on a step that uses no unit");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    sta.done |-> (state == ST_WAIT))
    else $error("unit finished while nothing was waiting");

endmodule

// ----- rtl/core/regeneration_time_statistics_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regeneration_time_statistics_top
// online visit statistics of a sampling chain: counts returns to a state,
// keeps running means and centred sums, reports frequency, gap variation,
// slope and correlation
// ----------------------------------------------------------------------------
//
//  channel | direction | payload    | transaction
//  --------+-----------+------------+---------------------------------------
//  in      | input     | rts_in_t   | one visit record or one report request
//  out     | output    | rts_out_t  | one report, none for a visit
//
//  each step on the shared restoring divider (one quotient bit per cycle),
//  multiplier or square root waits in the sequencer until that unit is done
//  reset is synchronous and clears every running mean, sum and count at once
//  in_stall is high from acceptance until the last step of the sequence
//  a finished report waits in the output register; the next item is taken
//  while it waits, and only a second report holds at its final step
//
module regeneration_time_statistics_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rts_pkg::rts_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output rts_pkg::rts_out_t out_item
);

  logic              in_take;
  logic              out_take;
  rts_pkg::rts_cmd_t cmd;
  rts_pkg::rts_sta_t sta;

  // transaction strobes on each side
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // sequencer
  rts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_op     (in_item.op),
    .out_take  (out_take),
    .sta       (sta),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // arithmetic and running state
  rts_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_take  (in_take),
    .in_item  (in_item),
    .cmd      (cmd),
    .sta      (sta),
    .out_item (out_item)
  );

endmodule

// ----- tb/tb_regeneration_time_statistics_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_regeneration_time_statistics_top
// self-checking bench: visit and report transactions go in, every report is
// compared field by field with a bit-exact fixed-point prediction of the
// running visit statistics, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_regeneration_time_statistics_top;

  typedef logic [63:0]  u64_t;
  typedef logic [127:0] u128_t;

  localparam int   IBITS       = rts_pkg::ITER_BITS;
  localparam int   FBITS       = rts_pkg::FRAC_BITS;
  localparam u64_t ITER_MASK   = (64'd1 << IBITS) - 1;
  localparam int   DRAIN_CYC   = 800;   // idle time after the last report is checked
  localparam int   MAX_SHOWN   = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  rts_pkg::rts_in_t  in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  rts_pkg::rts_out_t out_item;

  // idling switch shared by both channels
  bit idle_on = 1'b0;
  int stall_left = 0;
  int mismatches = 0;

  // predicted statistics state
  u64_t visits, last_iter;
  u64_t avg_index, avg_iter, avg_gap;
  u64_t ss_index, ss_iter, ss_gap, ss_cross;
  u64_t next_iter;   // running iteration for well-formed visit sequences

  rts_pkg::rts_out_t pending_reports[$];

  regeneration_time_statistics_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- helpers
  function automatic u64_t frac_drop_sat(u128_t p);
    if (p[127:64+FBITS] != '0) return '1;
    return p[64+FBITS-1:FBITS];
  endfunction

  function automatic u64_t quot_sat(u128_t x, u64_t d);
    if (x[127:64] >= d) return '1;
    return u64_t'(x / d);
  endfunction

  function automatic u64_t plus_sat(u64_t s, u64_t t);
    logic [64:0] w;
    w = {1'b0, s} + {1'b0, t};
    return w[64] ? '1 : w[63:0];
  endfunction

  function automatic u64_t int_sqrt(u64_t v);
    u64_t res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // one welford mean step: distance before and after, sign of the sample offset
  task automatic welford_step(inout u64_t avg, input u64_t x, input u64_t n,
                              output u64_t dist_pre, output u64_t dist_post,
                              output bit below);
    u64_t xf;
    xf = x << FBITS;
    below = xf < avg;
    dist_pre = below ? avg - xf : xf - avg;
    avg = below ? avg - dist_pre / n : avg + dist_pre / n;
    dist_post = below ? avg - xf : xf - avg;
  endtask

  task automatic record_visit(u64_t iter);
    u64_t gap, n, bx, ax, by, ay, bg, ag, mag, off;
    bit nx, ny, ng;
    gap = (iter - last_iter) & ITER_MASK;   // wraps modulo the iteration width
    last_iter = iter;
    if (visits < ITER_MASK) visits++;
    n = visits;
    welford_step(avg_index, n, n, bx, ax, nx);
    welford_step(avg_iter, iter, n, by, ay, ny);
    welford_step(avg_gap, gap, n, bg, ag, ng);
    ss_index = plus_sat(ss_index, frac_drop_sat(u128_t'(bx) * u128_t'(ax)));
    ss_iter  = plus_sat(ss_iter, frac_drop_sat(u128_t'(by) * u128_t'(ay)));
    ss_gap   = plus_sat(ss_gap, frac_drop_sat(u128_t'(bg) * u128_t'(ag)));
    // cross sum kept in offset binary so saturation is a plain unsigned clamp
    mag = frac_drop_sat(u128_t'(bx) * u128_t'(ay));
    off = ss_cross ^ rts_pkg::SIGN64;
    if (nx != ny) off = (off < mag) ? 64'd0 : off - mag;
    else off = plus_sat(off, mag);
    ss_cross = off ^ rts_pkg::SIGN64;
  endtask

  function automatic rts_pkg::rts_out_t build_report(u64_t total);
    rts_pkg::rts_out_t r;
    u64_t n, mxy, a, b, c, v;
    bit neg;
    r = '0;
    if (visits <= u64_t'(rts_pkg::MIN_VISITS)) return r;
    n = visits;
    neg = ss_cross[63];
    mxy = neg ? (~ss_cross + 64'd1) : ss_cross;
    r.enough_visits = 1'b1;
    if (total != 0) begin
      v = (n << FBITS) / total;
      r.frequency = rts_pkg::FRACQ_W'(v > rts_pkg::ONE_Q ? rts_pkg::ONE_Q : v);
    end
    if (avg_gap != 0) begin
      v = quot_sat(u128_t'(ss_gap) << FBITS, avg_gap);
      v = quot_sat(u128_t'(v) << FBITS, avg_gap);
      v = v / n / n;
      r.gap_variation = rts_pkg::OUT_W'(v > rts_pkg::LOW32 ? rts_pkg::LOW32 : v);
    end
    if (ss_index != 0) begin
      a = quot_sat(u128_t'(mxy) << FBITS, ss_index);
      if (last_iter != 0) begin
        v = quot_sat(u128_t'(a) * u128_t'(n), last_iter);
        if (neg) begin
          if (v > rts_pkg::SLOPE_NEG) v = rts_pkg::SLOPE_NEG;
          r.plot_slope = rts_pkg::OUT_W'(~v + 64'd1);
        end else begin
          r.plot_slope = rts_pkg::OUT_W'(v > rts_pkg::SLOPE_POS ? rts_pkg::SLOPE_POS : v);
        end
      end
      if (ss_iter != 0) begin
        b = quot_sat(u128_t'(mxy) << FBITS, ss_iter);
        c = frac_drop_sat(u128_t'(a) * u128_t'(b));
        if (c > rts_pkg::ONE_Q) c = rts_pkg::ONE_Q;
        v = int_sqrt(c << FBITS);
        r.correlation = rts_pkg::FRACQ_W'(v > rts_pkg::ONE_Q ? rts_pkg::ONE_Q : v);
      end
    end
    return r;
  endfunction

  // ------------------------------------------------------------ send / check
  // drives one transaction, predicts on acceptance, then maybe idles
  task automatic send(logic op, logic [IBITS-1:0] iter);
    in_item.op <= op;
    in_item.iteration <= iter;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == rts_pkg::OP_VISIT) record_visit(u64_t'(iter));
    else pending_reports.push_back(build_report(u64_t'(iter)));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic visit_next(int unsigned step);
    next_iter = (next_iter + step) & ITER_MASK;
    send(rts_pkg::OP_VISIT, IBITS'(next_iter));
  endtask

  // no transaction is offered while the sender waits
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_field(string fname, u64_t exp_v, u64_t got_v);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch %s: expected %0h actual %0h", fname, exp_v, got_v);
  endtask

  // report checker: oldest prediction against each accepted report
  always @(posedge clk) begin
    rts_pkg::rts_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("unexpected report %0h", out_item);
      end else begin
        want = pending_reports.pop_front();
        if (out_item.enough_visits !== want.enough_visits)
          report_field("enough_visits", want.enough_visits, out_item.enough_visits);
        if (out_item.frequency !== want.frequency)
          report_field("frequency", want.frequency, out_item.frequency);
        if (out_item.gap_variation !== want.gap_variation)
          report_field("gap_variation", want.gap_variation, out_item.gap_variation);
        if (out_item.plot_slope !== want.plot_slope)
          report_field("plot_slope", u64_t'(want.plot_slope), u64_t'(out_item.plot_slope));
        if (out_item.correlation !== want.correlation)
          report_field("correlation", want.correlation, out_item.correlation);
      end
    end
  end

  // ------------------------------------------------------------------ tests
  // reports before the sixth visit, and all the zero-divisor cases
  task automatic test_few_visits_and_zeros();
    send(rts_pkg::OP_REPORT, 24'd100);
    repeat (3) send(rts_pkg::OP_VISIT, 24'd0);
    send(rts_pkg::OP_REPORT, 24'd0);
    repeat (3) send(rts_pkg::OP_VISIT, 24'd0);   // six visits, no gaps, last iteration zero
    send(rts_pkg::OP_REPORT, 24'd0);
    send(rts_pkg::OP_REPORT, 24'd1);
    send(rts_pkg::OP_REPORT, 24'hFFFFFF);
    next_iter = 0;
    repeat (6) visit_next(37);
    send(rts_pkg::OP_REPORT, 24'd2);
    send(rts_pkg::OP_REPORT, 24'd5000);
    visit_next(0);                       // repeated iteration, zero gap
    send(rts_pkg::OP_REPORT, 24'd1000);
  endtask

  // well-formed visit runs with reports mixed in, plus some noise
  task automatic test_random_chain(int count);
    int unsigned sel;
    for (int k = 0; k < count; k++) begin
      if (k == count - 200) idle_on = 1'b0;   // closing stretch without idling
      sel = $urandom_range(0, 99);
      if (sel < 68) visit_next($urandom_range(1, 2000));
      else if (sel < 72) visit_next($urandom_range(0, 100000));
      else if (sel < 74) visit_next(0);
      else if (sel < 90) send(rts_pkg::OP_REPORT, IBITS'($urandom));
      else if (sel < 95)
        send(rts_pkg::OP_REPORT, IBITS'(next_iter + $urandom_range(0, 5000)));
      else if (sel < 97) send(rts_pkg::OP_REPORT, IBITS'($urandom_range(0, 3)));
      else send(rts_pkg::OP_REPORT, IBITS'(visits + $urandom_range(0, 50)));
    end
  endtask

  // sender holds off until every report is back, then carries on
  task automatic test_drain_pause();
    wait_drained();
    send(rts_pkg::OP_REPORT, IBITS'(next_iter));
    wait_drained();
    visit_next(11);
  endtask

  // wrapped gaps and huge swings that drive the sums into saturation
  task automatic test_wrap_and_overflow();
    send(rts_pkg::OP_VISIT, 24'hFFFF00);
    send(rts_pkg::OP_VISIT, 24'h000050);          // gap wraps round the counter
    send(rts_pkg::OP_REPORT, 24'hFFFFFF);
    send(rts_pkg::OP_VISIT, 24'hFFFFFF);
    send(rts_pkg::OP_VISIT, 24'h000000);
    send(rts_pkg::OP_VISIT, 24'hFFFFFF);
    send(rts_pkg::OP_REPORT, 24'hABCDEF);
    send(rts_pkg::OP_VISIT, 24'h555555);
    send(rts_pkg::OP_VISIT, 24'hAAAAAA);
    send(rts_pkg::OP_REPORT, 24'h800000);
    send(rts_pkg::OP_REPORT, 24'h000001);
  endtask

  initial begin
    visits = 0; last_iter = 0; avg_index = 0; avg_iter = 0; avg_gap = 0;
    ss_index = 0; ss_iter = 0; ss_gap = 0; ss_cross = 0; next_iter = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_few_visits_and_zeros();
    idle_on = 1'b1;
    test_random_chain(900);
    idle_on = 1'b1;
    test_drain_pause();
    test_wrap_and_overflow();
    test_random_chain(1000);
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rts_pkg.sv
rtl/core/rts_div.sv
rtl/core/rts_mul.sv
rtl/core/rts_dp.sv
rtl/core/rts_ctrl.sv
rtl/core/regeneration_time_statistics_top.sv
tb/tb_regeneration_time_statistics_top.sv
